// ===== hdl/assert_macros.svh =====
// assertion macros used by the packer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the default clock and reset names
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/cwlb_pkg.sv =====
// types, constants and helper functions of the common-width list bit packer
package cwlb_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned LenW  = 6;
  localparam int unsigned AccW  = 2 * WordW;

  typedef logic [WordW-1:0] word_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [AccW-1:0]  acc_t;

  // bits needed for one element, signed values carry a sign bit
  function automatic len_t need_width(word_t v, logic sgn);
    word_t mag;
    len_t  n;
    mag = (sgn && v[WordW-1]) ? (word_t'(0) - v) : v;
    n = len_t'(1);
    for (int i = 0; i < WordW; i++) begin
      if (mag[i]) n = len_t'(i + 1);
    end
    if (sgn) begin
      if (n > len_t'(31)) n = len_t'(31);
      n = n + len_t'(1);
    end
    return n;
  endfunction

  // low w bits set, w from 1 to 32
  function automatic word_t width_mask(len_t w);
    logic [WordW:0] m;
    m = ({{WordW{1'b0}}, 1'b1} << w) - {{WordW{1'b0}}, 1'b1};
    return m[WordW-1:0];
  endfunction

endpackage

// ===== hdl/common_width_list_bit_packer.sv =====
// Collects a list of 32-bit elements, one per input transfer, and on the last
// one emits a header holding (width - 1) in HEADER_BITS bits followed by every
// element at the widest width of the list, packed LSB-first into 32-bit words.
// A transfer that is not the last of its list produces no output. After the
// last transfer the block drops in_ready_o and drains the element RAM via a
// single append/shift unit, one element per cycle while the output side takes
// its full words; a partial final word is sent from a separate flush state.
// An empty-list request emits only a header word with HEADER_BITS valid bits.
// Elements beyond LIST_DEPTH are dropped and flagged on every word of that list.
module common_width_list_bit_packer #(
  parameter int unsigned LIST_DEPTH  = 16,
  parameter int unsigned HEADER_BITS = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cwlb_pkg::word_t value_i,
  input  logic            is_signed_i,
  input  logic            last_i,
  input  logic            empty_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cwlb_pkg::word_t word_o,
  output cwlb_pkg::len_t  valid_bits_o,
  output logic            final_word_o,
  output logic            overflowed_o
);

  import cwlb_pkg::*;

  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_EMPTY  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  len_t             widest_q, widest_d;
  logic             ovf_q, ovf_d;
  acc_t             acc_q, acc_d;
  len_t             fill_q, fill_d;

  logic             out_valid_q, out_valid_d;
  word_t            word_q, word_d;
  len_t             bits_q, bits_d;
  logic             final_q, final_d;
  logic             ovf_out_q, ovf_out_d;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  len_t              elem_w;
  logic              has_room;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  word_t             ram_rdata;
  word_t             elem;
  acc_t              acc_sum;
  len_t              fill_sum;
  logic [CNT_W-1:0]  idx_inc;
  logic              more;
  logic              full_word;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign elem_w     = need_width(value_i, is_signed_i);
  assign has_room   = (count_q < CNT_W'(LIST_DEPTH));

  assign elem      = ram_rdata & width_mask(widest_q);
  assign acc_sum   = acc_q | (AccW'(elem) << fill_q);
  assign fill_sum  = fill_q + widest_q;
  assign full_word = fill_sum[LenW-1];
  assign idx_inc   = idx_q + CNT_W'(1);
  assign more      = ({1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1}) < {1'b0, count_q};

  cwlb_ram #(
    .WIDTH (WordW),
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (count_q[ADDR_W-1:0]),
    .wr_data_i (value_i),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    widest_d  = widest_q;
    ovf_d     = ovf_q;
    acc_d     = acc_q;
    fill_d    = fill_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q[ADDR_W-1:0];
    out_load  = 1'b0;
    word_d    = word_q;
    bits_d    = bits_q;
    final_d   = final_q;
    ovf_out_d = ovf_out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (empty_req_i) begin
            state_d = S_EMPTY;
          end else begin
            if (has_room) begin
              ram_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
              if (elem_w > widest_q) widest_d = elem_w;
            end else begin
              ovf_d = 1'b1;
            end
            if (last_i) begin
              state_d = S_START;
              idx_d   = '0;
              acc_d   = AccW'(HEADER_BITS'(widest_d - len_t'(1)));
              fill_d  = LenW'(HEADER_BITS);
            end
          end
        end
      end
      S_START: begin
        ram_re  = 1'b1;
        state_d = S_APPEND;
      end
      S_APPEND: begin
        if (!full_word || out_free) begin
          if (full_word) begin
            out_load  = 1'b1;
            word_d    = acc_sum[WordW-1:0];
            bits_d    = len_t'(WordW);
            final_d   = !more && (fill_sum == len_t'(WordW));
            ovf_out_d = ovf_q;
            acc_d     = acc_sum >> WordW;
            fill_d    = fill_sum - len_t'(WordW);
          end else begin
            acc_d  = acc_sum;
            fill_d = fill_sum;
          end
          if (more) begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[ADDR_W-1:0];
            idx_d     = idx_inc;
          end else if (full_word && (fill_sum == len_t'(WordW))) begin
            state_d  = S_IDLE;
            count_d  = '0;
            widest_d = len_t'(1);
            ovf_d    = 1'b0;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load  = 1'b1;
          word_d    = acc_q[WordW-1:0];
          bits_d    = fill_q;
          final_d   = 1'b1;
          ovf_out_d = ovf_q;
          state_d   = S_IDLE;
          count_d   = '0;
          widest_d  = len_t'(1);
          ovf_d     = 1'b0;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load  = 1'b1;
          word_d    = '0;
          bits_d    = LenW'(HEADER_BITS);
          final_d   = 1'b1;
          ovf_out_d = ovf_q;
          state_d   = S_IDLE;
          count_d   = '0;
          widest_d  = len_t'(1);
          ovf_d     = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register holds a word until its transfer
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      widest_q    <= len_t'(1);
      ovf_q       <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      widest_q    <= widest_d;
      ovf_q       <= ovf_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    word_q    <= word_d;
    bits_q    <= bits_d;
    final_q   <= final_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign word_o       = word_q;
  assign valid_bits_o = bits_q;
  assign final_word_o = final_q;
  assign overflowed_o = ovf_out_q;

  `include "assert_macros.svh"

  `ASSERT_DEF(a_count_bound, count_q <= CNT_W'(LIST_DEPTH), "element count beyond store depth")
  `ASSERT_DEF(a_read_in_list, (state_q == S_APPEND) |-> (idx_q < count_q), "read past stored list")
  `ASSERT_DEF(a_flush_partial, (state_q == S_FLUSH) |-> (fill_q != '0 && !fill_q[LenW-1]), "flush without partial word")
  `ASSERT_DEF(a_bits_range, out_valid_o |-> (valid_bits_o != '0 && valid_bits_o <= len_t'(WordW)), "valid bit count out of range")
  `ASSERT_DEF(a_list_cleared, (out_valid_o && out_ready_i && final_word_o) |=> (count_q == '0 || !in_ready_o || $past(in_ready_o)), "list state not cleared after final word")

endmodule

// ===== hdl/cwlb_ram.sv =====
// generic single-write, single-read ram with registered read data
module cwlb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== test/tb.sv =====
// testbench for the common-width list bit packer: directed and random lists checked against a packing predictor
module tb;
  import cwlb_pkg::*;

  localparam int unsigned Depth   = 16;
  localparam int unsigned HdrBits = 5;
  localparam int unsigned MaxWords = (HdrBits + Depth * 32 + 31) / 32;
  localparam int unsigned PackW   = MaxWords * 32;
  localparam int unsigned NumItems = 300;

  typedef struct {
    word_t value;
    logic  sgn;
    logic  last;
    logic  empty;
    logic  hold;
  } list_item_t;

  typedef struct {
    word_t word;
    len_t  vbits;
    logic  fin;
    logic  ovf;
  } packed_word_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  word_t value_i     = '0;
  logic  is_signed_i = 1'b0;
  logic  last_i      = 1'b0;
  logic  empty_req_i = 1'b0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  word_t word_o;
  len_t  valid_bits_o;
  logic  final_word_o;
  logic  overflowed_o;

  common_width_list_bit_packer #(
    .LIST_DEPTH (Depth),
    .HEADER_BITS(HdrBits)
  ) u_top (.*);

  list_item_t   pending_items[$];
  packed_word_t expected_words[$];
  int           err_cnt  = 0;
  int           acc_cnt  = 0;
  int           sent_cnt = 0;

  // list state mirrored from the block
  word_t       elem_store[Depth];
  int unsigned elem_cnt = 0;
  int unsigned widest   = 1;
  logic        ovf_seen = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned bit_len(word_t x);
    int unsigned n;
    n = 1;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic int unsigned elem_width(word_t v, logic sgn);
    int unsigned n;
    if (!sgn) return bit_len(v);
    n = bit_len(v[31] ? word_t'(0) - v : v);
    if (n > 31) n = 31;
    return n + 1;
  endfunction

  task automatic clear_list();
    elem_cnt = 0;
    widest   = 1;
    ovf_seen = 1'b0;
  endtask

  // updates the list state and queues the packed words a list end produces
  task automatic pack_list_item(input list_item_t it);
    logic [PackW-1:0] bits;
    word_t            mask;
    int unsigned      pos, nw, rem;
    packed_word_t     pw;
    if (it.empty) begin
      pw = '{word: '0, vbits: len_t'(HdrBits), fin: 1'b1, ovf: ovf_seen};
      expected_words.push_back(pw);
      clear_list();
      return;
    end
    if (elem_cnt < Depth) begin
      elem_store[elem_cnt] = it.value;
      elem_cnt++;
      if (elem_width(it.value, it.sgn) > widest) widest = elem_width(it.value, it.sgn);
    end else begin
      ovf_seen = 1'b1;
    end
    if (!it.last) return;
    mask = (widest == 32) ? '1 : (word_t'(1) << widest) - word_t'(1);
    bits = PackW'(widest - 1);
    pos  = HdrBits;
    for (int i = 0; i < elem_cnt; i++) begin
      bits = bits | (PackW'(elem_store[i] & mask) << pos);
      pos += widest;
    end
    nw = (pos + 31) / 32;
    for (int i = 0; i < nw; i++) begin
      rem = pos - 32 * i;
      pw.word  = bits[i*32 +: 32];
      pw.vbits = len_t'(rem > 32 ? 32 : rem);
      pw.fin   = (i == nw - 1);
      pw.ovf   = ovf_seen;
      expected_words.push_back(pw);
    end
    clear_list();
  endtask

  task automatic add_item(input word_t v, input logic s, input logic l, input logic e,
                          input logic h = 1'b0);
    list_item_t it;
    it = '{value: v, sgn: s, last: l, empty: e, hold: h};
    pending_items.push_back(it);
  endtask

  function automatic word_t rand_elem(logic sgn);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return sgn ? word_t'(0) - ($urandom >> $urandom_range(1, 31))
                    : $urandom >> $urandom_range(20, 31);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hffff_ffff;
          3: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
    endcase
  endfunction

  // sender: bursts of transfers separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  always @(negedge clk_i) begin
    if (rst_ni && acc_cnt == sent_cnt) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].hold && expected_words.size() != 0)) begin
        in_valid_i  <= 1'b1;
        value_i     <= pending_items[0].value;
        is_signed_i <= pending_items[0].sgn;
        last_i      <= pending_items[0].last;
        empty_req_i <= pending_items[0].empty;
        void'(pending_items.pop_front());
        sent_cnt++;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between modes
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(1, 50);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // transfer monitor and word checker
  always @(posedge clk_i) begin
    list_item_t   it;
    packed_word_t exp_w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        it = '{value: value_i, sgn: is_signed_i, last: last_i, empty: empty_req_i,
               hold: 1'b0};
        pack_list_item(it);
        acc_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word %h", word_o);
          err_cnt++;
        end else begin
          exp_w = expected_words.pop_front();
          if (word_o !== exp_w.word) begin
            $error("word: expected %h, got %h", exp_w.word, word_o);
            err_cnt++;
          end
          if (valid_bits_o !== exp_w.vbits) begin
            $error("valid_bits: expected %0d, got %0d", exp_w.vbits, valid_bits_o);
            err_cnt++;
          end
          if (final_word_o !== exp_w.fin) begin
            $error("final_word: expected %b, got %b", exp_w.fin, final_word_o);
            err_cnt++;
          end
          if (overflowed_o !== exp_w.ovf) begin
            $error("overflowed: expected %b, got %b", exp_w.ovf, overflowed_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned n_items, len, mode, abort_at;
    logic        sgn;
    // directed lists
    add_item(32'hffff_ffff, 1'b1, 1'b1, 1'b1);
    add_item(32'h0000_0000, 1'b0, 1'b1, 1'b0);
    add_item(32'hffff_ffff, 1'b0, 1'b1, 1'b0);
    add_item(32'h8000_0000, 1'b1, 1'b1, 1'b0);
    add_item(32'hffff_ffff, 1'b1, 1'b0, 1'b0);
    add_item(32'h0000_0000, 1'b1, 1'b0, 1'b0);
    add_item(32'h7fff_ffff, 1'b1, 1'b1, 1'b0);
    add_item(32'h0000_0001, 1'b0, 1'b0, 1'b0);
    add_item(32'h0000_0002, 1'b0, 1'b1, 1'b0);
    add_item(32'h0000_0005, 1'b0, 1'b0, 1'b0);
    add_item(32'h0000_0000, 1'b0, 1'b1, 1'b1);
    for (int i = 0; i < Depth + 1; i++) begin
      add_item(i[0] ? word_t'(0) - word_t'(i) : word_t'(i) << (2 * i), 1'b1,
               (i == Depth), 1'b0);
    end
    // random lists; the first list and some randomly picked later ones wait for the block to drain
    n_items = 0;
    while (n_items < NumItems) begin
      if ($urandom_range(0, 99) < 8) begin
        add_item($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
        n_items++;
      end else begin
        mode = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
          0: len = $urandom_range(Depth + 1, Depth + 6);
          1, 2: len = $urandom_range(9, Depth);
          default: len = $urandom_range(1, 8);
        endcase
        abort_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < len; i++) begin
          sgn = (mode == 2) ? 1'($urandom_range(0, 1)) : mode[0];
          if (i == abort_at) begin
            add_item($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
            n_items++;
            break;
          end
          add_item(rand_elem(sgn), sgn, (i == len - 1), 1'b0,
                   (i == 0) && (n_items == 0 || $urandom_range(0, 49) == 0));
          n_items++;
        end
      end
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_items.size() != 0 || acc_cnt != sent_cnt || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== common_width_list_bit_packer.f =====
+incdir+hdl
hdl/cwlb_pkg.sv
hdl/cwlb_ram.sv
hdl/common_width_list_bit_packer.sv
test/tb.sv
